@@ hdl/mlfe_pkg.sv @@
package mlfe_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int FRAME_OVERHEAD  = 6;
  localparam int MAX_RESULTS     = 64;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CNT_RES_W       = 7;

  localparam logic [BYTE_W-1:0] START_ONE_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] START_TWO_RST = 8'h55;
  localparam logic [BYTE_W-1:0] END_ONE_RST   = 8'h55;
  localparam logic [BYTE_W-1:0] END_TWO_RST   = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST   = 6'd58;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ONE = 3'd0,
    REG_START_TWO = 3'd1,
    REG_END_ONE   = 3'd2,
    REG_END_TWO   = 3'd3,
    REG_MAX_LEN   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_one;
    logic [BYTE_W-1:0] start_two;
    logic [BYTE_W-1:0] end_one;
    logic [BYTE_W-1:0] end_two;
    logic [LEN_W-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_frame;
    logic              empty_frame;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

@@ hdl/mlfe_front.sv @@
module mlfe_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mlfe_pkg::BYTE_W-1:0] data_byte,
  output logic                       q_valid,
  output logic [mlfe_pkg::BYTE_W-1:0] q_data,
  input  logic                       q_pop
);
  import mlfe_pkg::*;

  // two-entry queue between the input channel and the scanner
  logic [1:0]        cnt;
  logic [1:0]        cnt_next;
  logic [1:0]        cnt_after_pop;
  logic [BYTE_W-1:0] data0;
  logic [BYTE_W-1:0] data1;
  logic [BYTE_W-1:0] data0_next;
  logic [BYTE_W-1:0] data1_next;
  logic              push;
  logic              pop;

  assign in_stall = (cnt == 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = data0;
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    data0_next    = data0;
    data1_next    = data1;
    cnt_after_pop = cnt - {1'b0, pop};
    if (pop) begin
      data0_next = data1;
    end
    if (push) begin
      if (cnt_after_pop == 2'd0) begin
        data0_next = data_byte;
      end else begin
        data1_next = data_byte;
      end
    end
    cnt_next = cnt_after_pop + {1'b0, push};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    data0 <= data0_next;
    data1 <= data1_next;
  end

endmodule

@@ hdl/mlfe_out_stage.sv @@
module mlfe_out_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_push,
  input  mlfe_pkg::result_t           res,
  output logic                        res_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mlfe_pkg::BYTE_W-1:0] payload_byte,
  output logic                        last_of_frame,
  output logic                        empty_frame,
  output logic [mlfe_pkg::LEN_W-1:0]  frame_length
);
  import mlfe_pkg::*;

  result_t held;

  assign res_ready     = !out_valid || !out_stall;
  assign payload_byte  = held.payload_byte;
  assign last_of_frame = held.last_of_frame;
  assign empty_frame   = held.empty_frame;
  assign frame_length  = held.frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      held <= res;
    end
  end

endmodule

@@ hdl/mlfe_scan.sv @@
module mlfe_scan #(
  parameter int STORE_DEPTH = mlfe_pkg::STORE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mlfe_pkg::cfg_t              cfg,
  input  logic                        cfg_wr,
  input  logic                        q_valid,
  input  logic [mlfe_pkg::BYTE_W-1:0] q_data,
  output logic                        q_pop,
  output logic                        res_push,
  output mlfe_pkg::result_t           res,
  input  logic                        res_ready
);
  import mlfe_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int OFF_W = (CW > 7) ? CW : 7;
  localparam int SUM_W = OFF_W + 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHK0   = 9'b000000010,
    S_CHK1   = 9'b000000100,
    S_LEN_LO = 9'b000001000,
    S_LEN_HI = 9'b000010000,
    S_END0   = 9'b000100000,
    S_END1   = 9'b001000000,
    S_EMPTY  = 9'b010000000,
    S_PAY    = 9'b100000000
  } state_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [OFF_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(STORE_DEPTH)) begin
      sum = sum - SUM_W'(STORE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [BYTE_W-1:0] store [STORE_DEPTH];
  logic [BYTE_W-1:0] mem_q;

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic [BYTE_W-1:0] len_lo, len_lo_next;
  logic [LEN_W-1:0]  len, len_next;
  logic              end0_ok, end0_ok_next;
  logic [LEN_W-1:0]  idx, idx_next;
  logic [CNT_RES_W-1:0] n, n_next;
  logic              byp, byp_next;
  logic [BYTE_W-1:0] byp_data, byp_data_next;
  logic              wait_vld, wait_vld_next;
  logic [OFF_W-1:0]  wait_need, wait_need_next;

  logic [OFF_W-1:0]  rd_off;
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     wr_idx;
  logic              mem_we;
  logic              do_drop;
  logic [OFF_W-1:0]  drop_len;
  logic [OFF_W-1:0]  count_ext;
  logic [BYTE_W-1:0] rd_byte;
  logic [LEN_W-1:0]  slots;
  logic [OFF_W-1:0]  need_lo;

  assign rd_byte   = byp ? byp_data : mem_q;
  assign count_ext = OFF_W'(count);
  assign wr_idx    = wrap_add(head, count_ext);
  assign slots     = (len == '0) ? LEN_W'(1) : len;
  assign need_lo   = OFF_W'(len_lo[LEN_W-1:0]) + OFF_W'(FRAME_OVERHEAD);

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    len_lo_next    = len_lo;
    len_next       = len;
    end0_ok_next   = end0_ok;
    idx_next       = idx;
    n_next         = n;
    byp_next       = 1'b0;
    byp_data_next  = byp_data;
    wait_vld_next  = wait_vld && !cfg_wr;
    wait_need_next = wait_need;
    rd_off         = '0;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    do_drop        = 1'b0;
    drop_len       = '0;
    res_push       = 1'b0;
    res            = '0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          mem_we = 1'b1;
          n_next = '0;
          if (count == CW'(STORE_DEPTH)) begin
            // window full: the new byte overwrites the oldest one
            rd_off        = OFF_W'(1);
            head_next     = wrap_add(head, OFF_W'(1));
            wait_vld_next = 1'b0;
            state_next    = S_CHK0;
          end else begin
            count_next    = count + CW'(1);
            byp_next      = (count == '0);
            byp_data_next = q_data;
            if (wait_vld && !cfg_wr && (count_ext + OFF_W'(1) < wait_need)) begin
              // the scan would stop at the same place again
              state_next = S_IDLE;
            end else begin
              wait_vld_next = 1'b0;
              state_next    = S_CHK0;
            end
          end
        end
      end
      S_CHK0: begin
        if (rd_byte != cfg.start_one) begin
          do_drop  = 1'b1;
          drop_len = OFF_W'(1);
        end else if (count < CW'(2)) begin
          wait_vld_next  = 1'b1;
          wait_need_next = OFF_W'(2);
          state_next     = S_IDLE;
        end else begin
          rd_off     = OFF_W'(1);
          state_next = S_CHK1;
        end
      end
      S_CHK1: begin
        if (rd_byte != cfg.start_two) begin
          // the second byte becomes the oldest: recheck it from the held copy
          do_drop       = 1'b1;
          drop_len      = OFF_W'(1);
          byp_next      = 1'b1;
          byp_data_next = rd_byte;
        end else if (count < CW'(4)) begin
          wait_vld_next  = 1'b1;
          wait_need_next = OFF_W'(4);
          state_next     = S_IDLE;
        end else begin
          rd_off     = OFF_W'(2);
          state_next = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        len_lo_next = rd_byte;
        rd_off      = OFF_W'(3);
        state_next  = S_LEN_HI;
      end
      S_LEN_HI: begin
        if ((rd_byte != '0) || (len_lo > BYTE_W'(cfg.max_len))) begin
          do_drop  = 1'b1;
          drop_len = OFF_W'(2);
        end else begin
          len_next = len_lo[LEN_W-1:0];
          if (count_ext < need_lo) begin
            wait_vld_next  = 1'b1;
            wait_need_next = need_lo;
            state_next     = S_IDLE;
          end else begin
            rd_off     = OFF_W'(4) + OFF_W'(len_lo[LEN_W-1:0]);
            state_next = S_END0;
          end
        end
      end
      S_END0: begin
        end0_ok_next = (rd_byte == cfg.end_one);
        rd_off       = OFF_W'(5) + OFF_W'(len);
        state_next   = S_END1;
      end
      S_END1: begin
        if (!end0_ok || (rd_byte != cfg.end_two)) begin
          do_drop  = 1'b1;
          drop_len = OFF_W'(2);
        end else if ((8'(n) + 8'(slots)) > 8'(MAX_RESULTS)) begin
          state_next = S_IDLE;
        end else if (len == '0) begin
          state_next = S_EMPTY;
        end else begin
          rd_off     = OFF_W'(4);
          idx_next   = '0;
          state_next = S_PAY;
        end
      end
      S_EMPTY: begin
        if (res_ready) begin
          res_push          = 1'b1;
          res.last_of_frame = 1'b1;
          res.empty_frame   = 1'b1;
          n_next            = n + CNT_RES_W'(1);
          do_drop           = 1'b1;
          drop_len          = OFF_W'(FRAME_OVERHEAD);
        end
      end
      S_PAY: begin
        rd_off = OFF_W'(4) + OFF_W'(idx);
        if (res_ready) begin
          res_push          = 1'b1;
          res.payload_byte  = rd_byte;
          res.last_of_frame = (idx == len - LEN_W'(1));
          res.frame_length  = len;
          n_next            = n + CNT_RES_W'(1);
          if (idx == len - LEN_W'(1)) begin
            do_drop  = 1'b1;
            drop_len = OFF_W'(len) + OFF_W'(FRAME_OVERHEAD);
          end else begin
            idx_next = idx + LEN_W'(1);
            rd_off   = OFF_W'(5) + OFF_W'(idx);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_drop) begin
      // read the new oldest byte while advancing past the dropped ones
      rd_off     = drop_len;
      head_next  = wrap_add(head, drop_len);
      count_next = CW'(count_ext - drop_len);
      state_next = (count_ext > drop_len) ? S_CHK0 : S_IDLE;
    end
    rd_idx = wrap_add(head, rd_off);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_idx] <= q_data;
    end
    mem_q <= store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      n        <= '0;
      byp      <= 1'b0;
      wait_vld <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      n        <= n_next;
      byp      <= byp_next;
      wait_vld <= wait_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    len_lo    <= len_lo_next;
    len       <= len_next;
    end0_ok   <= end0_ok_next;
    idx       <= idx_next;
    byp_data  <= byp_data_next;
    wait_need <= wait_need_next;
  end

endmodule

@@ hdl/marker_length_frame_extractor_unit.sv @@
// Marker/length deframer. Bytes of a serial stream enter on the input channel
// (in_valid, in_stall, data_byte); payload bytes of good frames leave on the
// output channel (out_valid, out_stall, payload_byte, last_of_frame,
// empty_frame, frame_length). A frame is two start bytes, a little-endian
// 16-bit length, the payload and two end bytes; marker values and the length
// limit come from the write port (cfg_we, cfg_index, cfg_data).
// A two-entry queue takes input bytes while the scanner works. The scanner
// takes in a byte that only extends an incomplete frame, drops each byte
// ahead of a start pair, rejects a bad start pair, length or end pair, and
// checks and sends a good frame of length L as max(L, 1) results, one result
// per cycle while the receiver does not stall. The window memory has a write
// port beside its read port, one read a cycle with registered data.
// Reset empties the window, the input queue and the output register, and
// loads the default markers.
// When the receiver stalls, the output register holds its transaction, the
// scanner waits, and the input queue fills and then raises in_stall.
module marker_length_frame_extractor_unit #(
  parameter int STORE_DEPTH = mlfe_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mlfe_pkg::BYTE_W-1:0]    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mlfe_pkg::BYTE_W-1:0]    payload_byte,
  output logic                          last_of_frame,
  output logic                          empty_frame,
  output logic [mlfe_pkg::LEN_W-1:0]     frame_length,
  input  logic                          cfg_we,
  input  logic [mlfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlfe_pkg::BYTE_W-1:0]    cfg_data
);
  import mlfe_pkg::*;

  cfg_t              cfg;
  logic              q_valid;
  logic [BYTE_W-1:0] q_data;
  logic              q_pop;
  logic              res_push;
  result_t           res;
  logic              res_ready;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_one <= START_ONE_RST;
      cfg.start_two <= START_TWO_RST;
      cfg.end_one   <= END_ONE_RST;
      cfg.end_two   <= END_TWO_RST;
      cfg.max_len   <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_ONE: cfg.start_one <= cfg_data;
        REG_START_TWO: cfg.start_two <= cfg_data;
        REG_END_ONE:   cfg.end_one   <= cfg_data;
        REG_END_TWO:   cfg.end_two   <= cfg_data;
        REG_MAX_LEN:   cfg.max_len   <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept input transactions into a short queue.
  mlfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  // Back: window memory and frame scanner.
  mlfe_scan #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_wr    (cfg_we),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: hold each result until the receiver takes it.
  mlfe_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res_push      (res_push),
    .res           (res),
    .res_ready     (res_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame),
    .empty_frame   (empty_frame),
    .frame_length  (frame_length)
  );

endmodule

@@ tb/marker_length_frame_extractor_unit_tb.sv @@
`timescale 1ns / 1ps

module marker_length_frame_extractor_unit_tb;
  import mlfe_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int WINDOW_DEPTH  = STORE_DEPTH_DEF;
  localparam int WIN_AW        = $clog2(WINDOW_DEPTH);
  // Settling time after the last owed transaction, with margin for a full rescan.
  localparam int SETTLE_CYCLES = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;
  localparam int SHORT_LEN     = 8;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    data_byte  = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [BYTE_W-1:0]    payload_byte;
  logic                 last_of_frame;
  logic                 empty_frame;
  logic [LEN_W-1:0]     frame_length;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_data   = '0;

  marker_length_frame_extractor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .last_of_frame(last_of_frame),
    .empty_frame  (empty_frame),
    .frame_length (frame_length),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shadow of the deframer: marker registers, byte window and the payload
  // transactions that are still owed on the output channel.
  cfg_t              markers;
  logic [BYTE_W-1:0] window_mem [WINDOW_DEPTH];
  int unsigned       window_head;
  int unsigned       window_fill;
  result_t           payload_q [$];

  int          idle_pct    = 0;    // percent chance per byte of an input idle burst, per cycle of a stall burst
  bit          hold_req    = 1'b0; // asks the receiver for one long hold-off
  int          mismatches  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent  = 0;

  function automatic logic [BYTE_W-1:0] window_at(input int unsigned ofs);
    return window_mem[WIN_AW'((window_head + ofs) % WINDOW_DEPTH)];
  endfunction

  function automatic void window_drop(input int unsigned n);
    if (n > window_fill) n = window_fill;
    window_head = (window_head + n) % WINDOW_DEPTH;
    window_fill -= n;
  endfunction

  // Append one byte, then scan the window from its oldest byte until it
  // either empties or has to wait for more data. Every good frame found
  // queues its payload transactions.
  function automatic void extract_frames(input logic [BYTE_W-1:0] b);
    int unsigned flen;
    int unsigned need;
    int unsigned slots;
    int unsigned produced;
    bit          waiting;
    result_t     r;
    produced = 0;
    waiting  = 1'b0;
    // Full window: the oldest byte makes room.
    if (window_fill >= WINDOW_DEPTH) window_drop(1);
    window_mem[WIN_AW'((window_head + window_fill) % WINDOW_DEPTH)] = b;
    window_fill++;
    while (window_fill > 0 && !waiting) begin
      if (window_at(0) != markers.start_one) begin
        window_drop(1);
      end else if (window_fill < 2) begin
        waiting = 1'b1;
      end else if (window_at(1) != markers.start_two) begin
        window_drop(1);
      end else if (window_fill < 4) begin
        waiting = 1'b1;
      end else begin
        flen = {16'h0000, window_at(3), window_at(2)};
        need = flen + FRAME_OVERHEAD;
        slots = (flen == 0) ? 1 : flen;
        if (flen > 32'(markers.max_len)) begin
          // Bad length: drop the start pair only and rescan.
          window_drop(2);
        end else if (window_fill < need) begin
          // Frame still arriving, or too big to ever fit: hold everything.
          waiting = 1'b1;
        end else if (window_at(4 + flen) != markers.end_one ||
                     window_at(5 + flen) != markers.end_two) begin
          window_drop(2);
        end else if (produced + slots > MAX_RESULTS) begin
          waiting = 1'b1;
        end else begin
          for (int unsigned i = 0; i < slots; i++) begin
            r.payload_byte  = (flen == 0) ? '0 : window_at(4 + i);
            r.last_of_frame = (i + 1 == slots);
            r.empty_frame   = (flen == 0);
            r.frame_length  = flen[LEN_W-1:0];
            payload_q.push_back(r);
          end
          produced += slots;
          window_drop(need);
        end
      end
    end
  endfunction

  // Offer one byte, optionally after an idle burst, and hold it until the
  // transaction goes through. Valid stays high for the next byte.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(12, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    extract_frames(b);
  endtask

  task automatic send_seq(input logic [BYTE_W-1:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Write enable stays high across back-to-back writes; load_markers lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_START_ONE: markers.start_one = val;
      REG_START_TWO: markers.start_two = val;
      REG_END_ONE:   markers.end_one   = val;
      REG_END_TWO:   markers.end_two   = val;
      REG_MAX_LEN:   markers.max_len   = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_markers(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                              input logic [BYTE_W-1:0] e1, input logic [BYTE_W-1:0] e2,
                              input logic [BYTE_W-1:0] max_len);
    write_reg(REG_START_ONE, s1);
    write_reg(REG_START_TWO, s2);
    write_reg(REG_END_ONE, e1);
    write_reg(REG_END_TWO, e2);
    write_reg(REG_MAX_LEN, max_len);
    cfg_we <= 1'b0;
  endtask

  // Bring the block to idle before a register write: push filler bytes that
  // can never start a frame until the window is empty, drop valid, collect
  // every owed transaction, then give the scanner time to finish.
  task automatic settle();
    logic [BYTE_W-1:0] filler;
    while (window_fill > 0) begin
      do filler = BYTE_W'($urandom_range(255)); while (filler == markers.start_one);
      send_byte(filler);
    end
    in_valid <= 1'b0;
    while (payload_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // end_kind: 0 good end pair, 1 bad first, 2 bad second, 3 both bad.
  task automatic send_frame(input int unsigned flen, input int end_kind);
    logic [BYTE_W-1:0] e1;
    logic [BYTE_W-1:0] e2;
    e1 = markers.end_one;
    e2 = markers.end_two;
    if (end_kind == 1 || end_kind == 3) e1 ^= BYTE_W'($urandom_range(255, 1));
    if (end_kind == 2 || end_kind == 3) e2 ^= BYTE_W'($urandom_range(255, 1));
    send_byte(markers.start_one);
    send_byte(markers.start_two);
    send_byte(flen[7:0]);
    send_byte(flen[15:8]);
    for (int unsigned i = 0; i < flen; i++) send_byte(BYTE_W'($urandom_range(255)));
    send_byte(e1);
    send_byte(e2);
  endtask

  function automatic int unsigned pick_len();
    int unsigned top;
    top = 32'(markers.max_len);
    // Mostly short frames; now and then anything up to the limit.
    if ($urandom_range(9) == 0) return $urandom_range(top);
    return $urandom_range((top < SHORT_LEN) ? top : SHORT_LEN);
  endfunction

  // Mostly well-formed frames with random payload; the rest is line noise,
  // broken headers, bad end pairs and frames cut short.
  task automatic random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned flen;
    logic [BYTE_W-1:0] second;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame(pick_len(), 0);
      end else if (pick < 70) begin
        send_frame(pick_len(), $urandom_range(3, 1));
      end else if (pick < 78) begin
        // Length over the limit, either just past it or via the high byte.
        if ($urandom_range(1) == 0) flen = 32'(markers.max_len) + $urandom_range(4, 1);
        else flen = $urandom_range(16'hFFFF, 16'h0100);
        send_byte(markers.start_one);
        send_byte(markers.start_two);
        send_byte(flen[7:0]);
        send_byte(flen[15:8]);
        repeat ($urandom_range(3)) send_byte(BYTE_W'($urandom_range(255)));
      end else if (pick < 86) begin
        repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
      end else if (pick < 93) begin
        do second = BYTE_W'($urandom_range(255)); while (second == markers.start_two);
        send_byte(markers.start_one);
        send_byte(second);
      end else begin
        // Truncated frame: the next frame's bytes land inside it.
        flen = pick_len();
        send_byte(markers.start_one);
        send_byte(markers.start_two);
        send_byte(flen[7:0]);
        send_byte(flen[15:8]);
        repeat ($urandom_range(flen)) send_byte(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic apply_reset();
    markers = '{START_ONE_RST, START_TWO_RST, END_ONE_RST, END_TWO_RST, MAX_LEN_RST};
    window_head = 0;
    window_fill = 0;
    foreach (window_mem[i]) window_mem[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Reset markers: stray bytes and a lone start byte, a one-byte frame,
  // a nonzero length high byte, a length just past the limit, and a bad
  // end pair whose rescan finds an empty frame hidden in its payload.
  task automatic test_directed();
    idle_pct = 25;
    send_seq('{8'h00, 8'hFF, markers.start_one, 8'h00});
    send_seq('{markers.start_one, markers.start_two, 8'h01, 8'h00, 8'hFF,
               markers.end_one, markers.end_two});
    send_seq('{markers.start_one, markers.start_two, 8'h00, 8'h01});
    send_seq('{markers.start_one, markers.start_two,
               BYTE_W'(int'(markers.max_len) + 1), 8'h00});
    send_seq('{markers.start_one, markers.start_two, 8'h02, 8'h00,
               markers.start_one, markers.start_two, 8'h00, 8'h00,
               markers.end_one, markers.end_two});
  endtask

  task automatic test_random_frames();
    idle_pct = 30;
    random_traffic(20);
  endtask

  // Random markers and limit; writes to unused indexes must change nothing.
  task automatic test_marker_settings();
    settle();
    idle_pct = 15;
    for (int i = int'(REG_MAX_LEN) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(i[CFG_IDX_W-1:0], BYTE_W'($urandom_range(255)));
    load_markers(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                 BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                 BYTE_W'($urandom_range(58, 1)));
    random_traffic(10);
  endtask

  // All-zero markers with only empty frames allowed, then all-ones markers
  // with the largest frame that fits the window.
  task automatic test_extremes();
    settle();
    idle_pct = 0;
    load_markers('0, '0, '0, '0, '0);
    random_traffic(5);
    settle();
    idle_pct = 20;
    load_markers('1, '1, '1, '1, 8'd58);
    send_frame(58, 0);
    random_traffic(5);
  endtask

  // Limit write of all ones masks to 63. A 60-byte frame can never fit the
  // window, so it waits until overflow pushes its start bytes out.
  task automatic test_overflow();
    settle();
    idle_pct = 10;
    load_markers(START_ONE_RST, START_TWO_RST, END_ONE_RST, END_TWO_RST, 8'hFF);
    send_byte(markers.start_one);
    send_byte(markers.start_two);
    send_byte(8'd60);
    send_byte(8'h00);
    repeat (62) send_byte(BYTE_W'($urandom_range(255)));
    send_frame(5, 0);
    random_traffic(5);
  endtask

  // Receiver holds off for a long stretch while frames keep coming, so the
  // output register, the scanner and the input queue all back up.
  task automatic test_backpressure();
    settle();
    idle_pct = 0;
    load_markers(START_ONE_RST, START_TWO_RST, END_ONE_RST, END_TWO_RST,
                 BYTE_W'(MAX_LEN_RST));
    hold_req = 1'b1;
    repeat (3) send_frame($urandom_range(10, 4), 0);
  endtask

  task automatic test_steady_finish();
    idle_pct = 0;
    random_traffic(15);
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (payload_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += payload_q.size();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  endtask

  initial begin
    apply_reset();
    test_directed();
    test_random_frames();
    test_marker_settings();
    test_extremes();
    test_overflow();
    test_backpressure();
    test_steady_finish();
    finish_run();
  end

  // Receiver: random stall bursts, plus the one long hold when asked.
  initial begin : receiver
    int burst;
    int hold_left;
    burst = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        burst = $urandom_range(12, 1) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Match each output transaction against the oldest owed payload byte.
  always @(posedge clk) begin : check_payload
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (payload_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected transaction: byte %02h last %0b empty %0b len %0d",
                   payload_byte, last_of_frame, empty_frame, frame_length);
      end else begin
        want = payload_q.pop_front();
        if (want.payload_byte !== payload_byte || want.last_of_frame !== last_of_frame ||
            want.empty_frame !== empty_frame || want.frame_length !== frame_length) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("payload mismatch: exp byte %02h last %0b empty %0b len %0d",
                     want.payload_byte, want.last_of_frame, want.empty_frame,
                     want.frame_length);
            $display("                  got byte %02h last %0b empty %0b len %0d",
                     payload_byte, last_of_frame, empty_frame, frame_length);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction means the block hung.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
hdl/mlfe_pkg.sv
hdl/mlfe_front.sv
hdl/mlfe_out_stage.sv
hdl/mlfe_scan.sv
hdl/marker_length_frame_extractor_unit.sv
tb/marker_length_frame_extractor_unit_tb.sv
